### rtl/sme_pkg.sv
// Package with shared types, opcodes and constants of the stack machine execute block.
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

   localparam int StackDepthDefault = 64;
   localparam int DataWordsDefault  = 256;
   localparam int LabelCountDefault = 256;

   typedef enum logic [4:0] {
      OP_NOP   = 5'd0,
      OP_LOADI = 5'd1,
      OP_LOAD  = 5'd2,
      OP_STO   = 5'd3,
      OP_POP   = 5'd4,
      OP_ADD   = 5'd5,
      OP_SUB   = 5'd6,
      OP_MULT  = 5'd7,
      OP_DIV   = 5'd8,
      OP_BRF   = 5'd9,
      OP_BR    = 5'd10,
      OP_EQ    = 5'd11,
      OP_NOTEQ = 5'd12,
      OP_GT    = 5'd13,
      OP_LES   = 5'd14,
      OP_GE    = 5'd15,
      OP_LE    = 5'd16,
      OP_IN    = 5'd17,
      OP_OUT   = 5'd18
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_DIVZERO   = 2'd3
   } status_type;

   typedef struct packed {
      logic [4:0]         opcode;
      logic signed [31:0] immediate;
      logic [7:0]         mem_address;
      logic [7:0]         label_number;
      logic signed [31:0] in_value;
   } req_type;

   typedef struct packed {
      logic               branch_taken;
      logic [7:0]         target_label;
      logic               out_valid;
      logic signed [31:0] out_value;
      logic [1:0]         status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic read_ops;
      logic div_start;
      logic execute;
      logic clear_step;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic div_needed;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

### rtl/sme_divider.sv
// Iterative signed divider with truncation, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sme_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend[31] ? (32'd0 - dividend) : dividend;
         den_in   = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in   = dividend[31] ^ divisor[31];
         count_in = 6'd32;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule
`default_nettype wire

### rtl/sme_datapath.sv
// Datapath: operand stack, data memory, stack pointer, ALU and result register.
`timescale 1ns / 1ps
`default_nettype none
module sme_datapath #(
   parameter int STACK_DEPTH = sme_pkg::StackDepthDefault,
   parameter int DATA_WORDS  = sme_pkg::DataWordsDefault,
   parameter int LABEL_COUNT = sme_pkg::LabelCountDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sme_pkg::req_type req,
   input  wire sme_pkg::cmd_type cmd,
   output sme_pkg::sts_type      sts,
   output sme_pkg::rsp_type      rsp
);

   localparam int SpW   = $clog2(STACK_DEPTH + 1);
   localparam int SiW   = $clog2(STACK_DEPTH);
   localparam int AddrW = $clog2(DATA_WORDS);
   localparam int LabW  = $clog2(LABEL_COUNT);

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] data_mem [DATA_WORDS];

   sme_pkg::req_type req_ff;
   logic [SpW-1:0]   sp_ff, sp_in;
   logic [31:0]      top_ff, below_ff, mem_rd_ff;
   logic [AddrW:0]   clr_ff;
   sme_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0]      mul_ff;

   logic             st_we, dm_we;
   logic [SiW-1:0]   st_wa;
   logic [31:0]      st_wd;
   logic [AddrW-1:0] addr;
   logic [AddrW-1:0] clr_addr;
   logic [7:0]       label;
   logic [31:0]      quotient;
   logic             div_done;
   logic [4:0]       op;
   logic [31:0]      r;
   logic [31:0]      fb, ft;
   logic             has1, has2, full;

   assign addr     = AddrW'(req_ff.mem_address);
   assign clr_addr = clr_ff[AddrW-1:0];
   assign op       = req_ff.opcode;
   assign fb       = below_ff ^ 32'h8000_0000;
   assign ft       = top_ff ^ 32'h8000_0000;
   assign has1     = sp_ff >= SpW'(1);
   assign has2     = sp_ff >= SpW'(2);
   assign full     = sp_ff >= SpW'(STACK_DEPTH);

   generate
      if (LabW >= 8) begin : g_lab_wide
         assign label = req_ff.label_number;
      end else begin : g_lab_narrow
         assign label = 8'(req_ff.label_number[LabW-1:0]);
      end
   endgenerate

   sme_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (below_ff),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      case (op)
         sme_pkg::OP_ADD:   r = below_ff + top_ff;
         sme_pkg::OP_SUB:   r = below_ff - top_ff;
         sme_pkg::OP_MULT:  r = mul_ff;
         sme_pkg::OP_DIV:   r = quotient;
         sme_pkg::OP_EQ:    r = {31'd0, below_ff == top_ff};
         sme_pkg::OP_NOTEQ: r = {31'd0, below_ff != top_ff};
         sme_pkg::OP_GT:    r = {31'd0, fb > ft};
         sme_pkg::OP_LES:   r = {31'd0, fb < ft};
         sme_pkg::OP_GE:    r = {31'd0, fb >= ft};
         default:           r = {31'd0, fb <= ft};
      endcase
   end

   always_comb begin
      sp_in  = sp_ff;
      rsp_in = rsp_ff;
      st_we  = 1'b0;
      st_wa  = SiW'(sp_ff);
      st_wd  = 32'd0;
      dm_we  = 1'b0;
      if (cmd.execute) begin
         rsp_in = '0;
         case (op)
            sme_pkg::OP_LOADI, sme_pkg::OP_LOAD, sme_pkg::OP_IN: begin
               if (full) begin
                  rsp_in.status = sme_pkg::ST_OVERFLOW;
               end else begin
                  st_we = 1'b1;
                  st_wd = (op == sme_pkg::OP_LOADI) ? req_ff.immediate :
                          (op == sme_pkg::OP_LOAD) ? mem_rd_ff : req_ff.in_value;
                  sp_in = sp_ff + SpW'(1);
               end
            end
            sme_pkg::OP_STO: begin
               if (!has1) rsp_in.status = sme_pkg::ST_UNDERFLOW;
               else dm_we = 1'b1;
            end
            sme_pkg::OP_POP, sme_pkg::OP_BRF, sme_pkg::OP_OUT: begin
               if (!has1) begin
                  rsp_in.status = sme_pkg::ST_UNDERFLOW;
               end else begin
                  sp_in = sp_ff - SpW'(1);
                  if (op == sme_pkg::OP_BRF && top_ff == 32'd0) begin
                     rsp_in.branch_taken = 1'b1;
                     rsp_in.target_label = label;
                  end
                  if (op == sme_pkg::OP_OUT) begin
                     rsp_in.out_valid = 1'b1;
                     rsp_in.out_value = top_ff;
                  end
               end
            end
            sme_pkg::OP_BR: begin
               rsp_in.branch_taken = 1'b1;
               rsp_in.target_label = label;
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MULT, sme_pkg::OP_DIV,
            sme_pkg::OP_EQ, sme_pkg::OP_NOTEQ, sme_pkg::OP_GT, sme_pkg::OP_LES,
            sme_pkg::OP_GE, sme_pkg::OP_LE: begin
               if (!has2) begin
                  rsp_in.status = sme_pkg::ST_UNDERFLOW;
               end else if (op == sme_pkg::OP_DIV && top_ff == 32'd0) begin
                  rsp_in.status = sme_pkg::ST_DIVZERO;
               end else begin
                  sp_in = sp_ff - SpW'(1);
                  st_we = 1'b1;
                  st_wa = SiW'(sp_ff - SpW'(2));
                  st_wd = r;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         clr_ff <= '0;
      end else begin
         sp_ff <= sp_in;
         if (cmd.clear_step) clr_ff <= clr_ff + (AddrW + 1)'(1);
      end
      if (cmd.capture) req_ff <= req;
      if (cmd.read_ops) begin
         top_ff    <= stack_mem[SiW'(sp_ff - SpW'(1))];
         below_ff  <= stack_mem[SiW'(sp_ff - SpW'(2))];
         mem_rd_ff <= data_mem[addr];
      end
      mul_ff <= below_ff * top_ff;
      rsp_ff <= rsp_in;
      if (st_we) stack_mem[st_wa] <= st_wd;
      if (cmd.clear_step) data_mem[clr_addr] <= 32'd0;
      else if (dm_we) data_mem[addr] <= top_ff;
   end

   assign sts.clear_done = clr_ff[AddrW];
   assign sts.div_needed = (op == sme_pkg::OP_DIV) && has2 && (top_ff != 32'd0);
   assign sts.div_done   = div_done;
   assign rsp            = rsp_ff;

endmodule
`default_nettype wire

### rtl/sme_controller.sv
// Controller state machine sequencing clear, capture, operand read, optional divide, execute and response.
`timescale 1ns / 1ps
`default_nettype none
module sme_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire sme_pkg::sts_type sts,
   output sme_pkg::cmd_type      cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_EXEC  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) state_in = S_IDLE;
            else cmd.clear_step = 1'b1;
         end
         S_IDLE: begin
            cmd.capture = 1'b1;
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            cmd.read_ops = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.div_needed) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule
`default_nettype wire

### rtl/stack_machine_execute.sv
// Top level of the stack machine execute block.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   sme_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   sme_pkg::rsp_type
//
// Each transaction passes through the capture, operand read, decide, execute
// and response states; a divide also waits in the bit-serial divider. After
// reset a clearing pass writes zero to every data memory word, with req_ready low.
// A new transaction is accepted only after the previous response is taken.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute #(
   parameter int STACK_DEPTH = sme_pkg::StackDepthDefault,
   parameter int DATA_WORDS  = sme_pkg::DataWordsDefault,
   parameter int LABEL_COUNT = sme_pkg::LabelCountDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sme_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sme_pkg::rsp_type      rsp_data
);

   sme_pkg::cmd_type cmd;
   sme_pkg::sts_type sts;

   sme_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sme_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WORDS  (DATA_WORDS),
      .LABEL_COUNT (LABEL_COUNT)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );

   a_no_ready_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response is pending");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.read_ops, cmd.div_start, cmd.execute, cmd.clear_step}))
      else $error("more than one datapath command");

   a_exec_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("execute not followed by response");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sme_pkg::ST_OK) |->
      (!rsp_data.branch_taken && !rsp_data.out_valid))
      else $error("error response carries branch or output");

endmodule
`default_nettype wire
